// File: sv/rgbse_pkg.sv
// ----------------------------------------------------------------------------
// rgbse_pkg
// Shared types and constants for the float-to-shared-exponent color encoder.
// ----------------------------------------------------------------------------
package rgbse_pkg;

  localparam int unsigned NumCh     = 3;
  localparam int unsigned FloatW    = 32;
  localparam int unsigned ExpW      = 8;
  localparam int unsigned FracW     = 23;
  localparam int unsigned SigW      = FracW + 1;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned ShiftW    = 5;
  // Width that holds 16 + max_exp - e without loss.
  localparam int unsigned ShiftSumW = ExpW + 2;

  localparam logic [ExpW-1:0]      ExpAllOnes = 8'hFF;
  localparam logic [ExpW-1:0]      MinBiased  = 8'd7;
  localparam logic [ExpW-1:0]      ExpOffset  = 8'd134;
  localparam logic [ShiftSumW-1:0] ShiftBase  = 10'd16;

  // Unpacked channel after the first stage.
  typedef struct packed {
    logic [SigW-1:0] sig;   // significand with hidden bit
    logic [ExpW-1:0] eeff;  // effective biased exponent (1 for subnormals)
  } chan_t;

  typedef struct packed {
    chan_t [NumCh-1:0] ch;
    logic [ExpW-1:0]   max_exp;
    logic              all_zero;
    logic              err;
  } s1_t;

  typedef struct packed {
    logic [NumCh-1:0][SigW-1:0]   sig;
    logic [NumCh-1:0][ShiftW-1:0] shift;
    logic [NumCh-1:0]             kill;      // shift of 32 or more
    logic [ExpW-1:0]              shared_exp;
    logic                         zero_out;  // force all fields to zero
    logic                         err;
  } s2_t;

  typedef struct packed {
    logic [NumCh-1:0][ByteW-1:0] bytes;
    logic [ExpW-1:0]             shared_exp;
    logic                        err;
  } res_t;

endpackage

// File: sv/rgbse_classify.sv
// ----------------------------------------------------------------------------
// rgbse_classify
// First stage: unpacks the three floats, flags bad input, finds the largest
// biased exponent.
// ----------------------------------------------------------------------------
module rgbse_classify (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               valid_i,
  output logic                                               ready_o,
  input  logic [rgbse_pkg::NumCh-1:0][rgbse_pkg::FloatW-1:0] bits_i,
  output logic                                               valid_o,
  input  logic                                               ready_i,
  output rgbse_pkg::s1_t                                     data_o
);

  logic           valid_q;
  rgbse_pkg::s1_t data_d, data_q;

  always_comb begin
    logic [rgbse_pkg::ExpW-1:0] e;
    logic [rgbse_pkg::ExpW-1:0] emax;
    logic                       zero;
    logic                       err;
    emax = '0;
    zero = 1'b1;
    err  = 1'b0;
    for (int i = 0; i < rgbse_pkg::NumCh; i++) begin
      e = bits_i[i][rgbse_pkg::FloatW-2 -: rgbse_pkg::ExpW];
      if (bits_i[i][rgbse_pkg::FloatW-2:0] != '0) begin
        zero = 1'b0;
        // A negative zero is still a zero; any other negative value is bad.
        if (bits_i[i][rgbse_pkg::FloatW-1]) begin
          err = 1'b1;
        end
      end
      if (e == rgbse_pkg::ExpAllOnes) begin
        err = 1'b1;
      end
      if (e > emax) begin
        emax = e;
      end
      data_d.ch[i].sig  = {(e != '0), bits_i[i][rgbse_pkg::FracW-1:0]};
      data_d.ch[i].eeff = (e == '0) ? rgbse_pkg::ExpW'(1) : e;
    end
    data_d.max_exp  = emax;
    data_d.all_zero = zero;
    data_d.err      = err;
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// File: sv/rgbse_align.sv
// ----------------------------------------------------------------------------
// rgbse_align
// Second stage: final error decision, shared exponent and per-channel
// shift amounts.
// ----------------------------------------------------------------------------
module rgbse_align (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  rgbse_pkg::s1_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output rgbse_pkg::s2_t data_o
);

  logic           valid_q;
  rgbse_pkg::s2_t data_d, data_q;

  always_comb begin
    logic [rgbse_pkg::ShiftSumW-1:0] sum;
    logic                            err;
    err = data_i.err || (!data_i.all_zero && (data_i.max_exp < rgbse_pkg::MinBiased));
    for (int i = 0; i < rgbse_pkg::NumCh; i++) begin
      // On the normal path max_exp is at least 7 and never below eeff.
      sum = rgbse_pkg::ShiftBase
          + rgbse_pkg::ShiftSumW'(data_i.max_exp)
          - rgbse_pkg::ShiftSumW'(data_i.ch[i].eeff);
      data_d.sig[i]   = data_i.ch[i].sig;
      data_d.shift[i] = sum[rgbse_pkg::ShiftW-1:0];
      data_d.kill[i]  = (sum[rgbse_pkg::ShiftSumW-1:rgbse_pkg::ShiftW] != '0);
    end
    data_d.shared_exp = data_i.max_exp - rgbse_pkg::ExpOffset;
    data_d.zero_out   = err || data_i.all_zero;
    data_d.err        = err;
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// File: sv/rgbse_scale.sv
// ----------------------------------------------------------------------------
// rgbse_scale
// Third stage: shifts each significand into a byte and holds the result
// register that faces the output.
// ----------------------------------------------------------------------------
module rgbse_scale (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  rgbse_pkg::s2_t  data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output rgbse_pkg::res_t data_o
);

  logic            valid_q;
  rgbse_pkg::res_t data_d, data_q;

  always_comb begin
    logic [rgbse_pkg::SigW-1:0] shifted;
    for (int i = 0; i < rgbse_pkg::NumCh; i++) begin
      shifted = data_i.sig[i] >> data_i.shift[i];
      if (data_i.zero_out || data_i.kill[i]) begin
        data_d.bytes[i] = '0;
      end else begin
        data_d.bytes[i] = shifted[rgbse_pkg::ByteW-1:0];
      end
    end
    data_d.shared_exp = data_i.zero_out ? '0 : data_i.shared_exp;
    data_d.err        = data_i.err;
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// File: sv/rgb_float_to_shared_exponent.sv
// Throughput: one item per cycle when not stalled; every stage takes a new
// item whenever it is empty or its contents move on, so bubbles close up
// under a stall.
// Reset: rst_ni is asynchronous and active low; it empties all three stages.
// The three register stages are classify, align and scale.
// ----------------------------------------------------------------------------
// rgb_float_to_shared_exponent
// Encodes three non-negative single-precision color channels as three bytes
// that share one signed exponent.
// ----------------------------------------------------------------------------
//
// The largest channel sets the shared exponent (its biased exponent minus
// 134), which places that channel's value in 128..255. Every channel byte is
// its 24-bit significand shifted right by 16 plus its exponent gap to the
// largest channel, truncated. An all-zero pixel gives zero bytes and exponent
// zero. A negative channel (other than negative zero), an infinity or NaN, or
// a largest exponent that would put the shared exponent below -127 raises the
// error flag on tuser and forces every byte and the exponent to zero.
//
// Stage one unpacks the floats, checks them and picks the largest biased
// exponent. Stage two settles the error, the shared exponent and the shift
// for each channel. Stage three runs the three barrel shifters; its register
// drives the output.
module rgb_float_to_shared_exponent (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0 up: red_bits[31:0], green_bits[63:32], blue_bits[95:64].
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0 up: red_byte[7:0], green_byte[15:8], blue_byte[23:16],
  // shared_exponent[31:24] (signed).
  output logic [31:0] m_axis_tdata,
  // Fields: input_error[0].
  output logic        m_axis_tuser
);

  logic [rgbse_pkg::NumCh-1:0][rgbse_pkg::FloatW-1:0] in_bits;

  logic            s1_valid, s1_ready;
  rgbse_pkg::s1_t  s1_data;
  logic            s2_valid, s2_ready;
  rgbse_pkg::s2_t  s2_data;
  rgbse_pkg::res_t res;

  // Channel 0 is red and sits in the lowest bits of the input word.
  assign in_bits = s_axis_tdata;

  rgbse_classify u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .bits_i  (in_bits),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  rgbse_align u_align (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  rgbse_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (res)
  );

  assign m_axis_tdata = {res.shared_exp, res.bytes[2], res.bytes[1], res.bytes[0]};
  assign m_axis_tuser = res.err;

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the float-to-shared-exponent color encoder.
// ----------------------------------------------------------------------------
//
// Pixels are queued by the stimulus process. A driver clocked on the falling
// edge feeds them to the slave port. A monitor on the rising edge does two
// jobs. It predicts the encoded color of every pixel that the block takes.
// It also compares each result that leaves the master port, field by field,
// with the oldest prediction. The run starts with hand-picked corner pixels.
// It then goes through four flow-control mixes, and it ends with a long
// output hold that backs the block up into its input.

module tb_top;

  localparam int unsigned ClkHalf    = 4;
  localparam int unsigned ResetLen   = 11;
  localparam int unsigned HoldLen    = 200;
  localparam int unsigned BurstLen   = 55;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxReports = 10;

  // Float layout and encoder constants.
  localparam logic [7:0] ExpInfNan  = 8'hFF;
  localparam logic [7:0] LowestTop  = 8'd7;    // smallest usable largest exponent
  localparam logic [7:0] BiasOffset = 8'd134;  // biased exponent to shared exponent
  localparam int         ByteShift  = 16;      // 24-bit significand down to a byte

  // One encoded color as the block should present it.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] sexp;
    logic       bad;
  } rgbe_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // Fields from bit 0 up: red_bits[31:0], green_bits[63:32], blue_bits[95:64].
  logic [95:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // Fields from bit 0 up: red_byte, green_byte, blue_byte, shared_exponent.
  logic [31:0] m_axis_tdata;
  // Fields: input_error[0].
  logic        m_axis_tuser;

  rgb_float_to_shared_exponent dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  logic [95:0] pixel_q[$];          // pixels waiting to be offered
  rgbe_t       expected_rgbe_q[$];  // predictions for pixels inside the block

  int unsigned pushed_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned result_count   = 0;
  int unsigned mismatch_count = 0;
  int unsigned flagged_count  = 0;
  int unsigned zero_count     = 0;
  int unsigned cycle_count    = 0;
  int unsigned directed_count = 0;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        hold_mode     = 1'b0;
  int unsigned hold_cycles   = 0;
  logic        in_taken      = 1'b0;

  initial begin
    forever #ClkHalf clk_i = ~clk_i;
  end

  // Byte of one channel once the largest biased exponent is known. A
  // subnormal has no hidden bit and behaves as if its exponent were one.
  function automatic logic [7:0] channel_byte(logic [30:0] mag, logic [7:0] top_exp);
    logic [7:0]  e;
    logic [23:0] sig;
    int          sh;
    e   = mag[30:23];
    sig = {1'b1, mag[22:0]};
    if (e == 8'd0) begin
      e       = 8'd1;
      sig[23] = 1'b0;
    end
    sh = ByteShift + int'(top_exp) - int'(e);
    if (sh >= 32) begin
      return 8'd0;
    end
    return 8'(sig >> sh);
  endfunction

  function automatic rgbe_t encode_rgbe(logic [95:0] px);
    logic [31:0] ch;
    logic [30:0] mag[3];
    logic [30:0] top;
    rgbe_t       res;
    res = '0;
    top = '0;
    for (int i = 0; i < 3; i++) begin
      ch     = px[32*i +: 32];
      mag[i] = ch[30:0];
      // Negative zero counts as zero; any other sign bit is an error.
      if (ch[31] && mag[i] != '0) res.bad = 1'b1;
      if (ch[30:23] == ExpInfNan) res.bad = 1'b1;
      if (mag[i] > top) top = mag[i];
    end
    if (top != '0 && top[30:23] < LowestTop) res.bad = 1'b1;
    if (!res.bad && top != '0) begin
      res.red   = channel_byte(mag[0], top[30:23]);
      res.green = channel_byte(mag[1], top[30:23]);
      res.blue  = channel_byte(mag[2], top[30:23]);
      res.sexp  = top[30:23] - BiasOffset;
    end
    return res;
  endfunction

  // A well-formed channel up to 20 octaves below the chosen top exponent,
  // with the occasional zero, negative zero or subnormal.
  function automatic logic [31:0] near_channel(logic [7:0] top_e);
    int unsigned k;
    int unsigned gap;
    logic [7:0]  e;
    k = $urandom_range(99);
    if (k < 4) return 32'h0000_0000;
    if (k < 8) return 32'h8000_0000;
    if (k < 14) return {9'h000, 23'($urandom)};
    gap = $urandom_range(0, 20);
    e   = (gap < top_e) ? top_e - 8'(gap) : 8'd1;
    return {1'b0, e, 23'($urandom)};
  endfunction

  // Raw bits, often bent toward infinity/NaN, a sign bit or a tiny exponent.
  function automatic logic [31:0] odd_channel();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(4))
      0: v[30:23] = ExpInfNan;
      1: v[31] = 1'b1;
      2: v[30:23] = 8'($urandom_range(0, 6));
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [95:0] random_pixel();
    logic [95:0] px;
    logic [7:0]  top_e;
    int unsigned k;
    logic        clean;
    k = $urandom_range(99);
    if (k < 10) top_e = 8'($urandom_range(7, 12));
    else if (k < 20) top_e = 8'($urandom_range(248, 254));
    else top_e = 8'($urandom_range(7, 254));
    clean = ($urandom_range(99) < 80);
    for (int i = 0; i < 3; i++) begin
      if (clean || $urandom_range(1) == 0) px[32*i +: 32] = near_channel(top_e);
      else px[32*i +: 32] = odd_channel();
    end
    return px;
  endfunction

  task automatic queue_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b);
    pixel_q.push_back({b, g, r});
    pushed_count++;
  endtask

  task automatic queue_random(int unsigned n);
    for (int i = 0; i < n; i++) begin
      pixel_q.push_back(random_pixel());
      pushed_count++;
    end
  endtask

  // Returns just after a rising edge once every queued pixel has been taken
  // and every prediction has been matched by a result.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (accepted_count != pushed_count || expected_rgbe_q.size() != 0);
    @(posedge clk_i);
  endtask

  task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MaxReports) begin
        $display("tb_top: result %0d %s expected %02h got %02h",
                 result_count, what, want, got);
      end
    end
  endtask

  // Sender: the next pixel goes out at the falling edge after the previous
  // one was taken, unless a random gap is drawn.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata  <= pixel_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a long hold counted here while hold_mode is on.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_mode && hold_cycles < HoldLen) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= hold_cycles + 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
    if (!hold_mode) hold_cycles <= 0;
  end

  // Monitor: checks results against the oldest prediction and predicts
  // every pixel the block takes.
  always @(posedge clk_i) begin
    rgbe_t want;
    in_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_rgbe_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("tb_top: unexpected result %08h user %0b", m_axis_tdata, m_axis_tuser);
          end
        end else begin
          want = expected_rgbe_q.pop_front();
          check_field("red_byte", want.red, m_axis_tdata[7:0]);
          check_field("green_byte", want.green, m_axis_tdata[15:8]);
          check_field("blue_byte", want.blue, m_axis_tdata[23:16]);
          check_field("shared_exponent", want.sexp, m_axis_tdata[31:24]);
          check_field("input_error", {7'd0, want.bad}, {7'd0, m_axis_tuser});
          if (want.bad) flagged_count++;
          else if (want == '0) zero_count++;
        end
        result_count++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_rgbe_q.push_back(encode_rgbe(s_axis_tdata));
        accepted_count++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top: timed out with %0d results outstanding", expected_rgbe_q.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (ResetLen) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corner pixels, no flow-control pressure.
    queue_pixel(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);  // all zero
    queue_pixel(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);  // all negative zero
    queue_pixel(32'h8000_0000, 32'h3F80_0000, 32'h0000_0000);  // -0 next to 1.0
    queue_pixel(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000);  // equal channels
    queue_pixel(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF);  // largest finite
    queue_pixel(32'h7F7F_FFFF, 32'h3F80_0000, 32'h0000_0001);  // huge shifts
    queue_pixel(32'hBF80_0000, 32'h3F80_0000, 32'h3F80_0000);  // negative red
    queue_pixel(32'h3F80_0000, 32'h7F80_0000, 32'h3F80_0000);  // infinity
    queue_pixel(32'h3F80_0000, 32'h3F80_0000, 32'h7FC0_0000);  // NaN
    queue_pixel(32'hFF80_0000, 32'h0000_0000, 32'h0000_0000);  // negative infinity
    queue_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // every bit set
    queue_pixel(32'h0300_0000, 32'h0000_0000, 32'h0000_0000);  // top exponent too low
    queue_pixel(32'h0380_0000, 32'h0000_0000, 32'h0000_0000);  // lowest usable top
    queue_pixel(32'h0000_0001, 32'h0000_0000, 32'h0000_0000);  // subnormal largest
    queue_pixel(32'h007F_FFFF, 32'h0000_0001, 32'h0000_0000);  // subnormals only
    queue_pixel(32'h0380_0000, 32'h007F_FFFF, 32'h0040_0000);  // subnormal smaller
    queue_pixel(32'h4780_0000, 32'h4000_0000, 32'h3F80_0000);  // shift 31 and 32
    queue_pixel(32'h4B7F_FFFF, 32'h4B00_0000, 32'h4AFF_FFFF);  // full significands
    queue_pixel(32'h7F00_0000, 32'h8000_0001, 32'h0000_0000);  // tiny negative
    queue_pixel(32'h0000_0000, 32'h0000_0000, 32'h2000_0000);  // only blue lit
    directed_count = pushed_count;
    wait_drained();

    // Four flow-control mixes; the sender also pauses for a full drain
    // between bursts.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 61; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 61; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      for (int b = 0; b < 3; b++) begin
        queue_random(BurstLen);
        wait_drained();
      end
    end

    // Long output hold with the sender running flat out: the pipeline fills
    // and must push back on its input until the hold ends.
    send_idle_pct = 0;
    stall_pct     = 20;
    hold_mode     = 1'b1;
    queue_random(60);
    wait_drained();
    hold_mode = 1'b0;

    // Leave room for anything stray to surface after the last result.
    repeat (10) @(posedge clk_i);
    if (expected_rgbe_q.size() != 0) mismatch_count++;

    $display("tb_top: %0d pixels (%0d hand-picked), %0d flagged bad, %0d all-zero results",
             accepted_count, directed_count, flagged_count, zero_count);
    $display({"tb_top: flow control covered free running, sender gaps, receiver stalls,",
              " both, and a %0d-cycle output hold"}, HoldLen);
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
